// File: hw/rtl/ted_pkg.sv
`default_nettype none

package ted_pkg;

   typedef enum logic [2:0] {
      ENC_UTF8    = 3'd0,
      ENC_UTF16LE = 3'd1,
      ENC_UTF16BE = 3'd2,
      ENC_GBK     = 3'd3,
      ENC_ASCII   = 3'd4
   } encoding_type;

   localparam logic [7:0] BOM_UTF8_0 = 8'hEF;
   localparam logic [7:0] BOM_UTF8_1 = 8'hBB;
   localparam logic [7:0] BOM_UTF8_2 = 8'hBF;
   localparam logic [7:0] BOM_FF     = 8'hFF;
   localparam logic [7:0] BOM_FE     = 8'hFE;

   localparam logic [7:0] GBK_LEAD_LOW   = 8'h81;
   localparam logic [7:0] GBK_LEAD_HIGH  = 8'hFE;
   localparam logic [7:0] GBK_TRAIL_LOW  = 8'h40;
   localparam logic [7:0] GBK_TRAIL_HIGH = 8'hFE;
   localparam logic [7:0] GBK_TRAIL_HOLE = 8'h7F;

   localparam logic [1:0] POS_MAX = 2'd3;

endpackage

`default_nettype wire

// File: hw/rtl/ted_req_if.sv
`default_nettype none

interface ted_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, data_byte, has_byte, last, input ready);
   modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ted_rsp_if.sv
`default_nettype none

interface ted_rsp_if;
   logic                  valid;
   logic                  ready;
   ted_pkg::encoding_type encoding;
   logic                  bom_seen;
   logic                  utf8_valid;
   logic                  gbk_valid;

   modport source (output valid, encoding, bom_seen, utf8_valid, gbk_valid, input ready);
   modport sink (input valid, encoding, bom_seen, utf8_valid, gbk_valid, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/text_encoding_detector.sv
// text_encoding_detector: classifies a byte stream as UTF-8, UTF-16LE, UTF-16BE,
// GBK or ASCII.
// req_chan: one transaction per byte (has_byte = 1) or an empty transaction
// (has_byte = 0); last = 1 closes the stream. A leading byte order mark decides
// the encoding, otherwise the UTF-8 structure check, then the GBK lead/trail
// check, else ASCII.
// rsp_chan: exactly one transaction per stream, issued for the transaction that
// carries last; utf8_valid and gbk_valid always report both checks.
// A last transaction goes through the input register, then the result register,
// before its result is shown on rsp_chan.
// Throughput: one transaction per cycle outside the stall below, set by the update
// of the small running state between the input register and the result register.
// Reset: synchronous; both registers empty, running state back to stream start.
// Stall: while rsp_chan is not taken, non-last transactions keep flowing; a
// second last transaction waits in the input register, and req_chan.ready drops
// only when that register holds it.
`default_nettype none

module text_encoding_detector (
   input  wire logic  clock,
   input  wire logic  reset,
   ted_req_if.sink    req_chan,
   ted_rsp_if.source  rsp_chan
);
   import ted_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_has_ff;
   logic       in_last_ff;
   logic       req_take;
   logic       s1_go;
   logic       out_free;

   logic [1:0] byte_position_ff, byte_position_in, byte_position_upd;
   logic       bom_utf8_ff, bom_utf8_in, bom_utf8_upd;
   logic       bom_le_ff, bom_le_in, bom_le_upd;
   logic       bom_be_ff, bom_be_in, bom_be_upd;
   logic [1:0] utf8_pending_ff, utf8_pending_in, utf8_pending_upd;
   logic       utf8_ok_ff, utf8_ok_in, utf8_ok_upd;
   logic       gbk_pending_ff, gbk_pending_in, gbk_pending_upd;
   logic       gbk_ok_ff, gbk_ok_in, gbk_ok_upd;

   logic         out_valid_ff, out_valid_in;
   encoding_type encoding_ff, encoding_in;
   logic         bom_seen_ff, bom_seen_in;
   logic         utf8_valid_ff, utf8_valid_in;
   logic         gbk_valid_ff, gbk_valid_in;

   // handshake
   assign out_free      = !out_valid_ff || rsp_chan.ready;
   assign s1_go         = in_valid_ff && (!in_last_ff || out_free);
   assign req_chan.ready = !in_valid_ff || s1_go;
   assign req_take      = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (s1_go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // state update for the byte in the input register
   always_comb begin
      byte_position_upd = byte_position_ff;
      bom_utf8_upd      = bom_utf8_ff;
      bom_le_upd        = bom_le_ff;
      bom_be_upd        = bom_be_ff;
      utf8_pending_upd  = utf8_pending_ff;
      utf8_ok_upd       = utf8_ok_ff;
      gbk_pending_upd   = gbk_pending_ff;
      gbk_ok_upd        = gbk_ok_ff;

      if (in_has_ff) begin
         unique case (byte_position_ff)
            2'd0: begin
               if (in_byte_ff != BOM_UTF8_0) bom_utf8_upd = 1'b0;
               if (in_byte_ff != BOM_FF) bom_le_upd = 1'b0;
               if (in_byte_ff != BOM_FE) bom_be_upd = 1'b0;
            end
            2'd1: begin
               if (in_byte_ff != BOM_UTF8_1) bom_utf8_upd = 1'b0;
               if (in_byte_ff != BOM_FE) bom_le_upd = 1'b0;
               if (in_byte_ff != BOM_FF) bom_be_upd = 1'b0;
            end
            2'd2: begin
               if (in_byte_ff != BOM_UTF8_2) bom_utf8_upd = 1'b0;
            end
            default: begin
            end
         endcase
         if (byte_position_ff != POS_MAX) byte_position_upd = byte_position_ff + 2'd1;

         if (utf8_ok_ff) begin
            priority if (utf8_pending_ff != 2'd0) begin
               if (in_byte_ff[7:6] == 2'b10) utf8_pending_upd = utf8_pending_ff - 2'd1;
               else utf8_ok_upd = 1'b0;
            end else if (in_byte_ff[7]) begin
               priority if (in_byte_ff[7:5] == 3'b110) utf8_pending_upd = 2'd1;
               else if (in_byte_ff[7:4] == 4'b1110) utf8_pending_upd = 2'd2;
               else if (in_byte_ff[7:3] == 5'b11110) utf8_pending_upd = 2'd3;
               else utf8_ok_upd = 1'b0;
            end else begin
            end
         end

         if (gbk_ok_ff) begin
            priority if (gbk_pending_ff) begin
               if (in_byte_ff < GBK_TRAIL_LOW || in_byte_ff == GBK_TRAIL_HOLE ||
                   in_byte_ff > GBK_TRAIL_HIGH) gbk_ok_upd = 1'b0;
               gbk_pending_upd = 1'b0;
            end else if (in_byte_ff[7]) begin
               if (in_byte_ff >= GBK_LEAD_LOW && in_byte_ff <= GBK_LEAD_HIGH)
                  gbk_pending_upd = 1'b1;
               else gbk_ok_upd = 1'b0;
            end else begin
            end
         end
      end
   end

   // result and end-of-stream clear
   always_comb begin
      utf8_valid_in = utf8_ok_upd && (utf8_pending_upd == 2'd0);
      gbk_valid_in  = gbk_ok_upd && !gbk_pending_upd;
      bom_seen_in   = 1'b1;
      priority if (byte_position_upd == POS_MAX && bom_utf8_upd) begin
         encoding_in = ENC_UTF8;
      end else if (byte_position_upd >= 2'd2 && bom_le_upd) begin
         encoding_in = ENC_UTF16LE;
      end else if (byte_position_upd >= 2'd2 && bom_be_upd) begin
         encoding_in = ENC_UTF16BE;
      end else begin
         bom_seen_in = 1'b0;
         if (utf8_valid_in) encoding_in = ENC_UTF8;
         else if (gbk_valid_in) encoding_in = ENC_GBK;
         else encoding_in = ENC_ASCII;
      end

      if (in_last_ff) begin
         byte_position_in = 2'd0;
         bom_utf8_in      = 1'b1;
         bom_le_in        = 1'b1;
         bom_be_in        = 1'b1;
         utf8_pending_in  = 2'd0;
         utf8_ok_in       = 1'b1;
         gbk_pending_in   = 1'b0;
         gbk_ok_in        = 1'b1;
      end else begin
         byte_position_in = byte_position_upd;
         bom_utf8_in      = bom_utf8_upd;
         bom_le_in        = bom_le_upd;
         bom_be_in        = bom_be_upd;
         utf8_pending_in  = utf8_pending_upd;
         utf8_ok_in       = utf8_ok_upd;
         gbk_pending_in   = gbk_pending_upd;
         gbk_ok_in        = gbk_ok_upd;
      end

      if (s1_go && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         byte_position_ff <= 2'd0;
         bom_utf8_ff      <= 1'b1;
         bom_le_ff        <= 1'b1;
         bom_be_ff        <= 1'b1;
         utf8_pending_ff  <= 2'd0;
         utf8_ok_ff       <= 1'b1;
         gbk_pending_ff   <= 1'b0;
         gbk_ok_ff        <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_go) begin
            byte_position_ff <= byte_position_in;
            bom_utf8_ff      <= bom_utf8_in;
            bom_le_ff        <= bom_le_in;
            bom_be_ff        <= bom_be_in;
            utf8_pending_ff  <= utf8_pending_in;
            utf8_ok_ff       <= utf8_ok_in;
            gbk_pending_ff   <= gbk_pending_in;
            gbk_ok_ff        <= gbk_ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_has_ff  <= req_chan.has_byte;
         in_last_ff <= req_chan.last;
      end
      if (s1_go && in_last_ff) begin
         encoding_ff   <= encoding_in;
         bom_seen_ff   <= bom_seen_in;
         utf8_valid_ff <= utf8_valid_in;
         gbk_valid_ff  <= gbk_valid_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.encoding   = encoding_ff;
   assign rsp_chan.bom_seen   = bom_seen_ff;
   assign rsp_chan.utf8_valid = utf8_valid_ff;
   assign rsp_chan.gbk_valid  = gbk_valid_ff;

   // state is back at stream start after a last transaction
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_go && in_last_ff |=> byte_position_ff == 2'd0 && utf8_ok_ff && gbk_ok_ff &&
         utf8_pending_ff == 2'd0 && !gbk_pending_ff)
      else $error("state not cleared after end of stream");

   a_bom_encoding: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.bom_seen |-> rsp_chan.encoding == ENC_UTF8 ||
         rsp_chan.encoding == ENC_UTF16LE || rsp_chan.encoding == ENC_UTF16BE)
      else $error("mark result with non-mark encoding");

   a_utf8_first: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.bom_seen && rsp_chan.utf8_valid |->
         rsp_chan.encoding == ENC_UTF8)
      else $error("valid utf-8 not reported as utf-8");

   a_gbk_second: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.bom_seen && !rsp_chan.utf8_valid &&
         rsp_chan.gbk_valid |-> rsp_chan.encoding == ENC_GBK)
      else $error("valid gbk not reported as gbk");

   a_no_stall_on_bytes: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_last_ff |-> req_chan.ready)
      else $error("input stalled on a non-last transaction");

endmodule

`default_nettype wire
